// File: hw/rtl/pas_pkg.sv
// shared types and constants for the page allocator free stack
// no dependencies

package pas_pkg;

    localparam int PAGE_W        = 12;
    localparam int STAT_W        = 2;
    localparam int MAX_PAGES_DEF = 4096;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// File: hw/rtl/page_allocator_free_stack_unit.sv
// page allocator top level: lifo free stack in ram plus bump pointer
// allocate: taken from the bump pointer, or popped from the stack through a registered ram read
// free: answered without a scan when out of range or pushed onto an empty stack, else after
// a duplicate scan reading one stack entry per cycle, then a push if no match is found
// one beat in flight; input stalls while busy or while a result waits behind a stalled output
// reset (synchronous, active low) zeroes counts and output valid; stack ram is not cleared

module page_allocator_free_stack_unit #(
    parameter int MAX_PAGES = pas_pkg::MAX_PAGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [pas_pkg::PAGE_W-1:0] i_page_id,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [pas_pkg::PAGE_W-1:0] o_granted_page,
    output logic [pas_pkg::STAT_W-1:0] o_status
);

    import pas_pkg::*;

    localparam int AW = $clog2(MAX_PAGES);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PAGE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [PAGE_W-1:0] ram_rdata;

    pas_ctrl #(
        .MAX_PAGES(MAX_PAGES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_page_id      (i_page_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted_page (o_granted_page),
        .o_status       (o_status),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    pas_ram #(
        .WIDTH(PAGE_W),
        .DEPTH(MAX_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// File: hw/rtl/pas_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies

module pas_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pas_ctrl.sv
// sequencer for allocate and free: pop, bump, duplicate scan, push, result register
// depends on pas_pkg; drives the free stack ram

module pas_ctrl #(
    parameter int MAX_PAGES = pas_pkg::MAX_PAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [pas_pkg::PAGE_W-1:0]         i_page_id,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pas_pkg::PAGE_W-1:0]         o_granted_page,
    output logic [pas_pkg::STAT_W-1:0]         o_status,
    output logic                               o_ram_we,
    output logic [$clog2(MAX_PAGES)-1:0]       o_ram_waddr,
    output logic [pas_pkg::PAGE_W-1:0]         o_ram_wdata,
    output logic                               o_ram_re,
    output logic [$clog2(MAX_PAGES)-1:0]       o_ram_raddr,
    input  logic [pas_pkg::PAGE_W-1:0]         i_ram_rdata
);

    import pas_pkg::*;

    localparam int AW   = $clog2(MAX_PAGES);
    localparam int CW   = $clog2(MAX_PAGES + 1);
    localparam int CMPW = (CW > PAGE_W) ? CW : PAGE_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_PAGES);

    typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_HOLD} t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fc, n_fc;
    logic [CW-1:0]       r_hw, n_hw;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_cmp_v, n_cmp_v;
    logic                r_cmp_last, n_cmp_last;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [PAGE_W-1:0]   r_res_g, n_res_g;
    t_status             r_res_s, n_res_s;
    logic                r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]   r_granted, n_granted;
    t_status             r_status, n_status;

    logic                slot_free;
    logic                fin;
    logic [PAGE_W-1:0]   fin_g;
    t_status             fin_s;
    logic [CW-1:0]       fc_m1;
    logic [CMPW-1:0]     hw_ext;
    logic [CMPW-1:0]     page_ext;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign fc_m1     = r_fc - CW'(1);
    assign hw_ext    = CMPW'(r_hw);
    assign page_ext  = CMPW'(i_page_id);

    always_comb begin
        n_state     = r_state;
        n_fc        = r_fc;
        n_hw        = r_hw;
        n_idx       = r_idx;
        n_cmp_v     = r_cmp_v;
        n_cmp_last  = r_cmp_last;
        n_page      = r_page;
        n_res_g     = r_res_g;
        n_res_s     = r_res_s;
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = r_page;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        fin         = 1'b0;
        fin_g       = '0;
        fin_s       = ST_OK;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_page = i_page_id;
                    if (i_cmd == CMD_ALLOC) begin
                        if (r_fc != '0) begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = fc_m1[AW-1:0];
                            n_fc        = fc_m1;
                            n_state     = S_POP;
                        end else if (r_hw < MAXC) begin
                            fin   = 1'b1;
                            fin_g = hw_ext[PAGE_W-1:0];
                            n_hw  = r_hw + CW'(1);
                        end else begin
                            fin   = 1'b1;
                            fin_s = ST_FULL;
                        end
                    end else begin
                        if (!(page_ext < hw_ext)) begin
                            fin   = 1'b1;
                            fin_s = ST_RANGE;
                        end else if (r_fc == '0) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = '0;
                            o_ram_wdata = i_page_id;
                            n_fc        = CW'(1);
                            fin         = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_cmp_v = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_POP: begin
                fin   = 1'b1;
                fin_g = i_ram_rdata;
            end
            S_SCAN: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_idx[AW-1:0];
                if (r_cmp_v && (i_ram_rdata == r_page)) begin
                    fin   = 1'b1;
                    fin_s = ST_DUP;
                end else if (r_cmp_v && r_cmp_last) begin
                    fin = 1'b1;
                    if (r_fc < MAXC) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_fc[AW-1:0];
                        n_fc        = r_fc + CW'(1);
                    end
                end else begin
                    n_cmp_v    = 1'b1;
                    n_cmp_last = (CW'(r_idx + CW'(1)) == r_fc);
                    n_idx      = r_idx + CW'(1);
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_granted   = r_res_g;
                    n_status    = r_res_s;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_granted   = fin_g;
                n_status    = fin_s;
                n_state     = S_IDLE;
            end else begin
                n_res_g = fin_g;
                n_res_s = fin_s;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fc        <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
            r_cmp_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fc        <= n_fc;
            r_hw        <= n_hw;
            r_out_valid <= n_out_valid;
            r_cmp_v     <= n_cmp_v;
        end
        r_idx      <= n_idx;
        r_cmp_last <= n_cmp_last;
        r_page     <= n_page;
        r_res_g    <= n_res_g;
        r_res_s    <= n_res_s;
        r_granted  <= n_granted;
        r_status   <= n_status;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_granted_page = r_granted;
    assign o_status       = r_status;

endmodule

// File: hw/rtl/pas_chk.sv
// port-level checks for the page allocator, bound to the top level
// depends on pas_pkg

module pas_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_cmd,
    input logic [pas_pkg::PAGE_W-1:0] i_page_id,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [pas_pkg::PAGE_W-1:0] o_granted_page,
    input logic [pas_pkg::STAT_W-1:0] o_status
);

    import pas_pkg::*;

    // no page handed out on any rejected beat
    a_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_RANGE || o_status == ST_DUP
                         || o_status == ST_FULL))
        |-> (o_granted_page == '0))
        else $error("granted page not zero on rejected beat");

    // reset leaves no result pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_granted_page) && $stable(o_status)))
        else $error("stalled result beat changed");

    // a stalled input beat keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall)
        |=> (i_in_valid && $stable(i_cmd) && $stable(i_page_id)))
        else $error("stalled input beat changed");

endmodule

bind page_allocator_free_stack_unit pas_chk u_chk (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench for page_allocator_free_stack_unit: directed table, then random allocate/free traffic
// expected grants come from a free-stack and bump-pointer predictor kept in this file, or from the table for typed rows
// depends on pas_pkg and the rtl of the allocator

module tb;
    import pas_pkg::*;

    typedef struct {
        logic [PAGE_W-1:0] granted;
        t_status           status;
    } t_grant_result;

    typedef struct {
        logic              cmd;
        logic [PAGE_W-1:0] page;
        int                reps;
        bit                typed;
        logic [PAGE_W-1:0] want_page;
        t_status           want_st;
    } t_dir_row;

    localparam int N_DIR_ROWS = 24;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    wire               in_stall;
    logic              in_cmd = CMD_ALLOC;
    logic [PAGE_W-1:0] in_page = '0;
    wire               out_valid;
    logic              out_stall = 1'b0;
    wire  [PAGE_W-1:0] out_granted;
    wire  [STAT_W-1:0] out_status;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // predictor state
    logic [PAGE_W-1:0] fs_pages [MAX_PAGES_DEF];
    int unsigned       fs_depth = 0;
    int unsigned       bump_next = 0;

    logic [PAGE_W-1:0] held_pages [$];
    t_grant_result     pending_grants [$];
    t_grant_result     head_grant;

    t_dir_row dir_rows [N_DIR_ROWS] = '{
        '{CMD_ALLOC, 12'hFFF, 1,    1'b1, 12'h000, ST_OK},
        '{CMD_FREE,  12'hFFF, 1,    1'b1, 12'h000, ST_RANGE},
        '{CMD_FREE,  12'h001, 1,    1'b1, 12'h000, ST_RANGE},
        '{CMD_FREE,  12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h000, 1,    1'b1, 12'h000, ST_DUP},
        '{CMD_ALLOC, 12'hAAA, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_ALLOC, 12'h555, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_ALLOC, 12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h001, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h002, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h001, 1,    1'b1, 12'h000, ST_DUP},
        '{CMD_FREE,  12'h000, 1,    1'b1, 12'h000, ST_DUP},
        '{CMD_FREE,  12'h003, 1,    1'b1, 12'h000, ST_RANGE},
        '{CMD_ALLOC, 12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_ALLOC, 12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_ALLOC, 12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'hFFF, 1,    1'b1, 12'h000, ST_RANGE},
        '{CMD_FREE,  12'h002, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h002, 1,    1'b1, 12'h000, ST_DUP},
        '{CMD_ALLOC, 12'h000, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'h555, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_FREE,  12'hAAA, 1,    1'b0, 12'h000, ST_OK},
        '{CMD_ALLOC, 12'h000, 1,    1'b0, 12'h000, ST_OK}
    };

    page_allocator_free_stack_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (in_cmd),
        .i_page_id      (in_page),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_granted_page (out_granted),
        .o_status       (out_status)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic void append_grant(input t_grant_result g);
        pending_grants.insert(pending_grants.size(), g);
    endfunction

    function automatic void append_held(input logic [PAGE_W-1:0] pg);
        held_pages.insert(held_pages.size(), pg);
    endfunction

    function automatic t_grant_result predict_page_op(input logic cmd,
                                                      input logic [PAGE_W-1:0] page);
        t_grant_result r;
        bit            found;
        int unsigned   i;
        r.granted = '0;
        r.status  = ST_OK;
        found     = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (fs_depth > 0) begin
                fs_depth--;
                r.granted = fs_pages[fs_depth];
            end else if (bump_next < MAX_PAGES_DEF) begin
                r.granted = PAGE_W'(bump_next);
                bump_next++;
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            for (i = 0; i < fs_depth; i++) begin
                if (fs_pages[i] == page) found = 1'b1;
            end
            if (page >= bump_next) begin
                r.status = ST_RANGE;
            end else if (found) begin
                r.status = ST_DUP;
            end else if (fs_depth < MAX_PAGES_DEF) begin
                fs_pages[fs_depth] = page;
                fs_depth++;
            end
        end
        return r;
    endfunction

    task automatic issue_request(input logic c, input logic [PAGE_W-1:0] pg,
                                 input bit typed, input t_grant_result typed_res);
        t_grant_result pred;
        int            i;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= c;
        in_page  <= pg;
        do @(posedge clk); while (in_stall);
        pred = predict_page_op(c, pg);
        append_grant(typed ? typed_res : pred);
        if (pred.status == ST_OK) begin
            if (c == CMD_ALLOC) begin
                append_held(pred.granted);
            end else begin
                for (i = 0; i < held_pages.size(); i++) begin
                    if (held_pages[i] == pg) begin
                        held_pages.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk);
    endtask

    task automatic send_random_items(input int count);
        int                k;
        int                pick;
        logic              c;
        logic [PAGE_W-1:0] pg;
        t_grant_result     none;
        none.granted = '0;
        none.status  = ST_OK;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            pg   = PAGE_W'($urandom_range(4095));
            c    = CMD_FREE;
            if (pick < 40) begin
                c = CMD_ALLOC;
            end else if (pick < 75 && held_pages.size() > 0) begin
                pg = held_pages[$urandom_range(held_pages.size() - 1)];
            end else if (pick < 85 && fs_depth > 0) begin
                pg = fs_pages[$urandom_range(fs_depth - 1)];
            end
            issue_request(c, pg, 1'b0, none);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random_items(count);
        drain_results();
    endtask

    // result beats
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_grants.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat page %0h status %0d",
                                        out_granted, out_status));
            end else begin
                head_grant = pending_grants.pop_front();
                if (out_granted !== head_grant.granted)
                    flag_mismatch($sformatf("granted page %0h, wanted %0h",
                                            out_granted, head_grant.granted));
                if (out_status !== head_grant.status)
                    flag_mismatch($sformatf("status %0d, wanted %0d",
                                            out_status, head_grant.status));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        t_grant_result typed_res;
        int            n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            typed_res.granted = dir_rows[r].want_page;
            typed_res.status  = dir_rows[r].want_st;
            for (n = 0; n < dir_rows[r].reps; n++) begin
                issue_request(dir_rows[r].cmd,
                              (dir_rows[r].reps > 1) ? PAGE_W'($urandom) : dir_rows[r].page,
                              dir_rows[r].typed, typed_res);
            end
        end
        drain_results();

        run_random_phase(64, 0, 30);
        run_random_phase(0, 64, 30);
        run_random_phase(0, 0, 30);
        run_random_phase(25, 25, 30);

        repeat (4200) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
